[design/bkr_pkg.sv]
// shared types and codes for the banker's safety allocator
package bkr_pkg;

  localparam int AMOUNT_W    = 8;
  localparam int FUNC_W      = 3;
  localparam int PROCESS_W   = 3;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int ACT_PROC_W  = 4;
  localparam int ACT_RES_W   = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_HELD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_NEED  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_AVAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REQUEST    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNSAFE     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXC_NEED   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EXC_AVAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EXC_HELD   = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PROCESSES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_RESOURCES = 2'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [PROCESS_W-1:0] process;
    logic [AMOUNT_W-1:0]  amount_0;
    logic [AMOUNT_W-1:0]  amount_1;
    logic [AMOUNT_W-1:0]  amount_2;
    logic [AMOUNT_W-1:0]  amount_3;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                safe;
  } out_item_t;

  // amount field of one resource column
  function automatic logic [AMOUNT_W-1:0] amount_of(in_item_t item, int idx);
    logic [AMOUNT_W-1:0] res;
    case (idx)
      0:       res = item.amount_0;
      1:       res = item.amount_1;
      2:       res = item.amount_2;
      3:       res = item.amount_3;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[design/bankers_safety_allocator.sv]
// banker's deadlock-avoidance allocator with an iterative safety scan
// sequence: accept, EXEC applies the operation, INIT loads the work vector, SCAN runs the passes
// over the np rows in use, P passes (1 to np); a refused unsafe request runs INIT and SCAN twice
// throughput: one transaction at a time, busy drops in the result cycle so the next can follow
// the scan unit checks and adds one process row per cycle against the work vector
// reset: synchronous active low; tables read as zero through per-row valid bits, no clearing
// pass; active_processes = 8, active_resources = 4
module bankers_safety_allocator #(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 4,
  parameter int UNIT_WIDTH    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  bkr_pkg::in_item_t                   in_data,
  // result channel
  output logic                                out_valid,
  output bkr_pkg::out_item_t                  out_data,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [bkr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bkr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int ROW_W  = $clog2(MAX_PROCESSES);
  localparam int NP_W   = $clog2(MAX_PROCESSES + 1);
  localparam int EXT_W  = (UNIT_WIDTH > bkr_pkg::AMOUNT_W) ? UNIT_WIDTH : bkr_pkg::AMOUNT_W;
  localparam int SUM_W  = EXT_W + 1;
  // work vector holds available plus every row's holdings without wrapping
  localparam int WORK_W = UNIT_WIDTH + $clog2(MAX_PROCESSES + 1);
  localparam logic [EXT_W-1:0] UNIT_MAX_X = EXT_W'({UNIT_WIDTH{1'b1}});

  typedef logic [MAX_RESOURCES-1:0][UNIT_WIDTH-1:0] row_t;
  typedef logic [MAX_RESOURCES-1:0][WORK_W-1:0]     work_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INIT,
    ST_SCAN
  } state_t;

  // control and registered outputs
  state_t                           state_r, state_nxt;
  bkr_pkg::in_item_t                item_r, item_nxt;
  logic [bkr_pkg::ACT_PROC_W-1:0]   ap_r, ap_nxt;
  logic [bkr_pkg::ACT_RES_W-1:0]    ar_r, ar_nxt;
  row_t                             avail_r, avail_nxt;
  logic [MAX_PROCESSES-1:0]         held_vld_r, held_vld_nxt;
  logic [MAX_PROCESSES-1:0]         need_vld_r, need_vld_nxt;
  logic                             trial_r, trial_nxt;
  row_t                             orig_held_r, orig_held_nxt;
  row_t                             orig_need_r, orig_need_nxt;
  row_t                             orig_avail_r, orig_avail_nxt;
  logic [bkr_pkg::STATUS_W-1:0]     status_r, status_nxt;
  work_t                            work_r, work_nxt;
  logic [MAX_PROCESSES-1:0]         fin_r, fin_nxt;
  logic [ROW_W-1:0]                 row_r, row_nxt;
  logic                             moved_r, moved_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bkr_pkg::out_item_t               out_data_r, out_data_nxt;

  // held and needed tables: one row of all resource columns per entry
  row_t                             held_mem [MAX_PROCESSES];
  row_t                             need_mem [MAX_PROCESSES];
  row_t                             held_rd_r, need_rd_r;
  logic                             held_rdv_r, need_rdv_r;
  logic [ROW_W-1:0]                 rd_addr, wr_addr;
  logic                             held_we, need_we;
  row_t                             held_wdata, need_wdata;
  row_t                             held_row, need_row;

  // decoded item and limits
  logic [NP_W-1:0]                  np;
  logic [bkr_pkg::ACT_RES_W-1:0]    nr;
  logic [MAX_RESOURCES-1:0]         col_act;
  logic [MAX_PROCESSES-1:0]         row_act_mask;
  logic [MAX_RESOURCES-1:0][EXT_W-1:0] amt_ext;
  row_t                             amt_u;
  logic                             big, row_ok, row_active, in_row_ok;
  logic                             exc_need, exc_avail, ovf_req, exc_held, ovf_rel;
  row_t                             req_held, req_need, req_avail;
  row_t                             rel_held, rel_need, rel_avail;

  // scan unit
  logic                             fits, last_row, all_fin, moved_any;
  work_t                            work_add;
  logic [MAX_PROCESSES-1:0]         fin_upd;
  logic [ROW_W-1:0]                 row_step;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // rows never written read as zero
  assign held_row = held_rdv_r ? held_rd_r : '0;
  assign need_row = need_rdv_r ? need_rd_r : '0;
  assign wr_addr  = ROW_W'(item_r.process);

  // register values out of range clamp to 1 or the maximum
  always_comb begin
    if (ap_r == '0) begin
      np = NP_W'(1);
    end else if (32'(ap_r) > MAX_PROCESSES) begin
      np = NP_W'(MAX_PROCESSES);
    end else begin
      np = NP_W'(ap_r);
    end
    if (ar_r == '0) begin
      nr = bkr_pkg::ACT_RES_W'(1);
    end else if (32'(ar_r) > MAX_RESOURCES) begin
      nr = bkr_pkg::ACT_RES_W'(MAX_RESOURCES);
    end else begin
      nr = ar_r;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_RESOURCES; c++) begin
      col_act[c] = (c < int'(nr));
    end
    for (int p = 0; p < MAX_PROCESSES; p++) begin
      row_act_mask[p] = (p < int'(np));
    end
  end

  assign row_ok     = (32'(item_r.process) < MAX_PROCESSES);
  assign row_active = row_ok && (32'(item_r.process) < 32'(np));
  assign in_row_ok  = (32'(in_data.process) < MAX_PROCESSES);

  // per-column checks and candidate rows for request and release
  always_comb begin
    big       = 1'b0;
    exc_need  = 1'b0;
    exc_avail = 1'b0;
    ovf_req   = 1'b0;
    exc_held  = 1'b0;
    ovf_rel   = 1'b0;
    for (int c = 0; c < MAX_RESOURCES; c++) begin
      amt_ext[c] = EXT_W'(bkr_pkg::amount_of(item_r, c));
      amt_u[c]   = UNIT_WIDTH'(amt_ext[c]);
      if (amt_ext[c] > UNIT_MAX_X) big = 1'b1;
      if (col_act[c]) begin
        if (amt_ext[c] > EXT_W'(need_row[c]))  exc_need  = 1'b1;
        if (amt_ext[c] > EXT_W'(avail_r[c]))   exc_avail = 1'b1;
        if (amt_ext[c] > EXT_W'(held_row[c]))  exc_held  = 1'b1;
        if (SUM_W'(held_row[c]) + SUM_W'(amt_ext[c]) > SUM_W'(UNIT_MAX_X)) ovf_req = 1'b1;
        if (SUM_W'(avail_r[c]) + SUM_W'(amt_ext[c]) > SUM_W'(UNIT_MAX_X) ||
            SUM_W'(need_row[c]) + SUM_W'(amt_ext[c]) > SUM_W'(UNIT_MAX_X)) begin
          ovf_rel = 1'b1;
        end
      end
      // inactive columns keep their values
      req_held[c]  = col_act[c] ? held_row[c] + amt_u[c] : held_row[c];
      req_need[c]  = col_act[c] ? need_row[c] - amt_u[c] : need_row[c];
      req_avail[c] = col_act[c] ? avail_r[c]  - amt_u[c] : avail_r[c];
      rel_held[c]  = col_act[c] ? held_row[c] - amt_u[c] : held_row[c];
      rel_need[c]  = col_act[c] ? need_row[c] + amt_u[c] : need_row[c];
      rel_avail[c] = col_act[c] ? avail_r[c]  + amt_u[c] : avail_r[c];
    end
  end

  // scan unit: one row checked against the work vector per cycle
  always_comb begin
    fits = !fin_r[row_r];
    for (int c = 0; c < MAX_RESOURCES; c++) begin
      if (col_act[c] && (WORK_W'(need_row[c]) > work_r[c])) fits = 1'b0;
      work_add[c] = work_r[c] + (col_act[c] ? WORK_W'(held_row[c]) : '0);
    end
    fin_upd = fin_r;
    if (fits) fin_upd[row_r] = 1'b1;
    last_row  = ((NP_W'(row_r) + NP_W'(1)) == np);
    all_fin   = &(fin_upd | ~row_act_mask);
    moved_any = moved_r | fits;
    row_step  = last_row ? '0 : row_r + ROW_W'(1);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    ap_nxt         = ap_r;
    ar_nxt         = ar_r;
    avail_nxt      = avail_r;
    held_vld_nxt   = held_vld_r;
    need_vld_nxt   = need_vld_r;
    trial_nxt      = trial_r;
    orig_held_nxt  = orig_held_r;
    orig_need_nxt  = orig_need_r;
    orig_avail_nxt = orig_avail_r;
    status_nxt     = status_r;
    work_nxt       = work_r;
    fin_nxt        = fin_r;
    row_nxt        = row_r;
    moved_nxt      = moved_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    held_we        = 1'b0;
    need_we        = 1'b0;
    held_wdata     = held_row;
    need_wdata     = need_row;
    rd_addr        = '0;

    if (cfg_we) begin
      case (cfg_index)
        bkr_pkg::REG_ACTIVE_PROCESSES: ap_nxt = cfg_wdata;
        bkr_pkg::REG_ACTIVE_RESOURCES: ar_nxt = cfg_wdata[bkr_pkg::ACT_RES_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        // fetch the addressed row while the transaction is taken
        rd_addr = in_row_ok ? ROW_W'(in_data.process) : '0;
        if (start) begin
          item_nxt   = in_data;
          status_nxt = bkr_pkg::STATUS_OK;
          trial_nxt  = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_INIT;
        case (item_r.func)
          bkr_pkg::FUNC_LOAD_HELD, bkr_pkg::FUNC_LOAD_NEED: begin
            if (row_ok) begin
              if (big) begin
                status_nxt = bkr_pkg::STATUS_OVERFLOW;
              end else if (item_r.func == bkr_pkg::FUNC_LOAD_HELD) begin
                held_we               = 1'b1;
                held_wdata            = amt_u;
                held_vld_nxt[wr_addr] = 1'b1;
              end else begin
                need_we               = 1'b1;
                need_wdata            = amt_u;
                need_vld_nxt[wr_addr] = 1'b1;
              end
            end
          end
          bkr_pkg::FUNC_LOAD_AVAIL: begin
            if (big) begin
              status_nxt = bkr_pkg::STATUS_OVERFLOW;
            end else begin
              avail_nxt = amt_u;
            end
          end
          bkr_pkg::FUNC_REQUEST: begin
            if (row_active) begin
              if (exc_need) begin
                status_nxt = bkr_pkg::STATUS_EXC_NEED;
              end else if (exc_avail) begin
                status_nxt = bkr_pkg::STATUS_EXC_AVAIL;
              end else if (ovf_req) begin
                status_nxt = bkr_pkg::STATUS_OVERFLOW;
              end else begin
                // apply on trial, keep the old values for rollback
                trial_nxt             = 1'b1;
                orig_held_nxt         = held_row;
                orig_need_nxt         = need_row;
                orig_avail_nxt        = avail_r;
                held_we               = 1'b1;
                need_we               = 1'b1;
                held_wdata            = req_held;
                need_wdata            = req_need;
                held_vld_nxt[wr_addr] = 1'b1;
                need_vld_nxt[wr_addr] = 1'b1;
                avail_nxt             = req_avail;
              end
            end
          end
          bkr_pkg::FUNC_RELEASE: begin
            if (row_active) begin
              if (exc_held) begin
                status_nxt = bkr_pkg::STATUS_EXC_HELD;
              end else if (ovf_rel) begin
                status_nxt = bkr_pkg::STATUS_OVERFLOW;
              end else begin
                held_we               = 1'b1;
                need_we               = 1'b1;
                held_wdata            = rel_held;
                need_wdata            = rel_need;
                held_vld_nxt[wr_addr] = 1'b1;
                need_vld_nxt[wr_addr] = 1'b1;
                avail_nxt             = rel_avail;
              end
            end
          end
          default: ;  // query and unused codes change nothing
        endcase
      end

      ST_INIT: begin
        // work vector starts at the available units, row 0 fetched
        for (int c = 0; c < MAX_RESOURCES; c++) begin
          work_nxt[c] = col_act[c] ? WORK_W'(avail_r[c]) : '0;
        end
        fin_nxt   = '0;
        row_nxt   = '0;
        moved_nxt = 1'b0;
        rd_addr   = '0;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        rd_addr   = row_step;
        row_nxt   = row_step;
        fin_nxt   = fin_upd;
        moved_nxt = last_row ? 1'b0 : moved_any;
        if (fits) work_nxt = work_add;
        // a pass that finishes nothing, or all rows finished, ends the scan
        if (last_row && (all_fin || !moved_any)) begin
          if (trial_r && !all_fin) begin
            // unsafe trial: restore the row and available units, scan again
            held_we    = 1'b1;
            need_we    = 1'b1;
            held_wdata = orig_held_r;
            need_wdata = orig_need_r;
            avail_nxt  = orig_avail_r;
            trial_nxt  = 1'b0;
            status_nxt = bkr_pkg::STATUS_UNSAFE;
            state_nxt  = ST_INIT;
          end else begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = status_r;
            out_data_nxt.safe   = all_fin;
            trial_nxt           = 1'b0;
            state_nxt           = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      item_r       <= '0;
      ap_r         <= bkr_pkg::ACT_PROC_W'(8);
      ar_r         <= bkr_pkg::ACT_RES_W'(4);
      avail_r      <= '0;
      held_vld_r   <= '0;
      need_vld_r   <= '0;
      trial_r      <= 1'b0;
      orig_held_r  <= '0;
      orig_need_r  <= '0;
      orig_avail_r <= '0;
      status_r     <= bkr_pkg::STATUS_OK;
      work_r       <= '0;
      fin_r        <= '0;
      row_r        <= '0;
      moved_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      item_r       <= item_nxt;
      ap_r         <= ap_nxt;
      ar_r         <= ar_nxt;
      avail_r      <= avail_nxt;
      held_vld_r   <= held_vld_nxt;
      need_vld_r   <= need_vld_nxt;
      trial_r      <= trial_nxt;
      orig_held_r  <= orig_held_nxt;
      orig_need_r  <= orig_need_nxt;
      orig_avail_r <= orig_avail_nxt;
      status_r     <= status_nxt;
      work_r       <= work_nxt;
      fin_r        <= fin_nxt;
      row_r        <= row_nxt;
      moved_r      <= moved_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  // table memories with registered read
  always_ff @(posedge clk) begin
    if (held_we) held_mem[wr_addr] <= held_wdata;
    if (need_we) need_mem[wr_addr] <= need_wdata;
    held_rd_r  <= held_mem[rd_addr];
    need_rd_r  <= need_mem[rd_addr];
    held_rdv_r <= held_vld_r[rd_addr];
    need_rdv_r <= need_vld_r[rd_addr];
  end

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  // a result strobe only follows work in progress
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // only a request is ever rolled back as unsafe
  a_unsafe_is_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == bkr_pkg::STATUS_UNSAFE)) |->
      (item_r.func == bkr_pkg::FUNC_REQUEST))
    else $error("unsafe status on a non-request transaction");

  // a trial allocation exists only for a request
  a_trial_is_request: assert property (@(posedge clk) disable iff (!rst_n)
    trial_r |-> (item_r.func == bkr_pkg::FUNC_REQUEST))
    else $error("trial allocation outside a request");

endmodule

[bench/tb_bankers_safety_allocator.sv]
// self-checking testbench for the banker's safety allocator
`timescale 1ns / 100ps

module tb_bankers_safety_allocator;

  // codes the package leaves unnamed: they must change nothing
  localparam logic [bkr_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [bkr_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int ROWS            = 8;
  localparam int COLS            = 4;
  localparam int UNIT_MAX        = 255;
  localparam int ITEMS_PER_PHASE = 82;
  localparam int N_PHASES        = 8;
  // every operation gives a result, so a short pause covers a config write
  localparam int SETTLE_CYCLES   = 4;
  // worst case: refused unsafe request, two scans of 8 rows over 8 passes each
  localparam int DRAIN_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  bkr_pkg::in_item_t               in_data;
  logic                            out_valid;
  bkr_pkg::out_item_t              out_data;
  logic                            cfg_we;
  logic [bkr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bkr_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  bankers_safety_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // allocation predictor: own copy of the tables and of both registers
  // ---------------------------------------------------------------------------
  logic [7:0] held_tab [ROWS][COLS];
  logic [7:0] need_tab [ROWS][COLS];
  logic [7:0] free_units [COLS];
  logic [3:0] proc_reg;
  logic [2:0] res_reg;

  // expected status/safe verdicts, oldest first
  bkr_pkg::out_item_t verdict_q [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int          burst_left;

  // register value to rows/columns in use, clamped to 1..max
  function automatic int rows_used();
    if (proc_reg == 0) return 1;
    if (proc_reg > ROWS) return ROWS;
    return proc_reg;
  endfunction

  function automatic int cols_used();
    if (res_reg == 0) return 1;
    if (res_reg > COLS) return COLS;
    return res_reg;
  endfunction

  // iterative scan: finish any row whose needs fit, then reclaim its holdings
  function automatic bit state_is_safe();
    int unsigned work [COLS];
    bit          done [ROWS];
    int          np;
    int          nr;
    bit          moved;
    bit          fits;
    np = rows_used();
    nr = cols_used();
    for (int r = 0; r < COLS; r++) work[r] = (r < nr) ? free_units[r] : 0;
    for (int p = 0; p < ROWS; p++) done[p] = 1'b0;
    for (int pass = 0; pass < np; pass++) begin
      moved = 1'b0;
      for (int p = 0; p < np; p++) begin
        if (!done[p]) begin
          fits = 1'b1;
          for (int r = 0; r < nr; r++) if (need_tab[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            done[p] = 1'b1;
            for (int r = 0; r < nr; r++) work[r] += held_tab[p][r];
            moved = 1'b1;
          end
        end
      end
      if (!moved) break;
    end
    for (int p = 0; p < np; p++) if (!done[p]) return 1'b0;
    return 1'b1;
  endfunction

  // apply one operation to the predicted tables and give its verdict
  function automatic bkr_pkg::out_item_t apply_operation(bkr_pkg::in_item_t it);
    logic [7:0]                   amt [COLS];
    logic [bkr_pkg::STATUS_W-1:0] st;
    int                           nr;
    int                           p;
    bit                           active;
    bkr_pkg::out_item_t           res;
    amt[0] = it.amount_0;
    amt[1] = it.amount_1;
    amt[2] = it.amount_2;
    amt[3] = it.amount_3;
    nr     = cols_used();
    p      = it.process;
    active = p < rows_used();
    st     = bkr_pkg::STATUS_OK;
    case (it.func)
      // loads write every column and any row, active or not
      bkr_pkg::FUNC_LOAD_HELD: begin
        for (int r = 0; r < COLS; r++) held_tab[p][r] = amt[r];
      end
      bkr_pkg::FUNC_LOAD_NEED: begin
        for (int r = 0; r < COLS; r++) need_tab[p][r] = amt[r];
      end
      bkr_pkg::FUNC_LOAD_AVAIL: begin
        for (int r = 0; r < COLS; r++) free_units[r] = amt[r];
      end
      bkr_pkg::FUNC_REQUEST: begin
        if (active) begin
          // checks in order: need, then free units, then held overflow
          for (int r = 0; r < nr; r++)
            if (st == bkr_pkg::STATUS_OK && amt[r] > need_tab[p][r])
              st = bkr_pkg::STATUS_EXC_NEED;
          for (int r = 0; r < nr; r++)
            if (st == bkr_pkg::STATUS_OK && amt[r] > free_units[r])
              st = bkr_pkg::STATUS_EXC_AVAIL;
          for (int r = 0; r < nr; r++)
            if (st == bkr_pkg::STATUS_OK && int'(held_tab[p][r]) + int'(amt[r]) > UNIT_MAX)
              st = bkr_pkg::STATUS_OVERFLOW;
          if (st == bkr_pkg::STATUS_OK) begin
            // grant on trial, roll back if the scan fails
            for (int r = 0; r < nr; r++) begin
              free_units[r]  -= amt[r];
              held_tab[p][r] += amt[r];
              need_tab[p][r] -= amt[r];
            end
            if (!state_is_safe()) begin
              for (int r = 0; r < nr; r++) begin
                free_units[r]  += amt[r];
                held_tab[p][r] -= amt[r];
                need_tab[p][r] += amt[r];
              end
              st = bkr_pkg::STATUS_UNSAFE;
            end
          end
        end
      end
      bkr_pkg::FUNC_RELEASE: begin
        if (active) begin
          for (int r = 0; r < nr; r++)
            if (st == bkr_pkg::STATUS_OK && amt[r] > held_tab[p][r])
              st = bkr_pkg::STATUS_EXC_HELD;
          for (int r = 0; r < nr; r++)
            if (st == bkr_pkg::STATUS_OK &&
                (int'(free_units[r]) + int'(amt[r]) > UNIT_MAX ||
                 int'(need_tab[p][r]) + int'(amt[r]) > UNIT_MAX))
              st = bkr_pkg::STATUS_OVERFLOW;
          if (st == bkr_pkg::STATUS_OK) begin
            for (int r = 0; r < nr; r++) begin
              free_units[r]  += amt[r];
              held_tab[p][r] -= amt[r];
              need_tab[p][r] += amt[r];
            end
          end
        end
      end
      default: ;
    endcase
    res.status = st;
    res.safe   = state_is_safe();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random operations shaped by the predicted state
  // ---------------------------------------------------------------------------
  function automatic bkr_pkg::in_item_t pick_operation();
    logic [bkr_pkg::FUNC_W-1:0] f;
    logic [2:0]                 p;
    logic [7:0]                 a [COLS];
    int                         roll;
    int                         lim;
    bit                         wild;
    roll = $urandom_range(0, 99);
    if (roll < 8)       f = bkr_pkg::FUNC_LOAD_HELD;
    else if (roll < 16) f = bkr_pkg::FUNC_LOAD_NEED;
    else if (roll < 22) f = bkr_pkg::FUNC_LOAD_AVAIL;
    else if (roll < 57) f = bkr_pkg::FUNC_REQUEST;
    else if (roll < 82) f = bkr_pkg::FUNC_RELEASE;
    else if (roll < 94) f = bkr_pkg::FUNC_QUERY;
    else if (roll < 97) f = FUNC_SPARE_6;
    else                f = FUNC_SPARE_7;
    // mostly rows in use, now and then any row
    p = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, ROWS - 1))
                                    : 3'($urandom_range(0, rows_used() - 1));
    for (int r = 0; r < COLS; r++) begin
      // an occasional full-range amount breaks the well-formed pattern; inactive columns always get one
      wild = ($urandom_range(0, 7) == 0) || (r >= cols_used());
      case (f)
        bkr_pkg::FUNC_LOAD_HELD, bkr_pkg::FUNC_LOAD_NEED, bkr_pkg::FUNC_LOAD_AVAIL: lim = 40;
        bkr_pkg::FUNC_REQUEST: begin
          lim = need_tab[p][r];
          if (free_units[r] < lim) lim = free_units[r];
          if (UNIT_MAX - held_tab[p][r] < lim) lim = UNIT_MAX - held_tab[p][r];
        end
        bkr_pkg::FUNC_RELEASE: begin
          lim = held_tab[p][r];
          if (UNIT_MAX - free_units[r] < lim) lim = UNIT_MAX - free_units[r];
          if (UNIT_MAX - need_tab[p][r] < lim) lim = UNIT_MAX - need_tab[p][r];
        end
        default: lim = UNIT_MAX;
      endcase
      a[r] = wild ? 8'($urandom_range(0, UNIT_MAX)) : 8'($urandom_range(0, lim));
    end
    return {f, p, a[0], a[1], a[2], a[3]};
  endfunction

  // sender bursts: runs back to back, then a random gap
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan: operations and register writes in one list
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                              is_cfg;
    logic [bkr_pkg::CFG_INDEX_W-1:0] idx;
    logic [bkr_pkg::CFG_DATA_W-1:0]  val;
    bkr_pkg::in_item_t               item;
    bit                              typed;
    bkr_pkg::out_item_t              want;
  } plan_row_t;

  function automatic plan_row_t row(logic [bkr_pkg::FUNC_W-1:0] f, int p, int a0, int a1,
                                    int a2, int a3);
    plan_row_t s;
    s.is_cfg = 1'b0;
    s.idx    = bkr_pkg::REG_ACTIVE_PROCESSES;
    s.val    = '0;
    s.item   = {f, 3'(p), 8'(a0), 8'(a1), 8'(a2), 8'(a3)};
    s.typed  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  // row whose verdict is written down by hand
  function automatic plan_row_t row_chk(logic [bkr_pkg::FUNC_W-1:0] f, int p, int a0, int a1,
                                        int a2, int a3, logic [bkr_pkg::STATUS_W-1:0] st,
                                        bit sf);
    plan_row_t s;
    s             = row(f, p, a0, a1, a2, a3);
    s.typed       = 1'b1;
    s.want.status = st;
    s.want.safe   = sf;
    return s;
  endfunction

  function automatic plan_row_t row_cfg(logic [bkr_pkg::CFG_INDEX_W-1:0] idx, int v);
    plan_row_t s;
    s        = row(bkr_pkg::FUNC_QUERY, 0, 0, 0, 0, 0);
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = bkr_pkg::CFG_DATA_W'(v);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // driving: inputs move on the falling edge, handshakes sampled on the rising
  // ---------------------------------------------------------------------------
  task automatic issue(input bkr_pkg::in_item_t it, input bit typed,
                       input bkr_pkg::out_item_t want, input int gap);
    bkr_pkg::out_item_t predicted;
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transaction taken at this edge
    predicted = apply_operation(it);
    verdict_q.push_back(typed ? want : predicted);
    @(negedge clk);
    // start is only lowered when a gap follows, so it never toggles within one step
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // register writes only with no transaction outstanding
  task automatic write_reg(input logic [bkr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bkr_pkg::CFG_DATA_W-1:0] val);
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bkr_pkg::REG_ACTIVE_PROCESSES) proc_reg = val;
    else if (idx == bkr_pkg::REG_ACTIVE_RESOURCES) res_reg = val[2:0];
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // result checking: every strobe against the oldest verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    bkr_pkg::out_item_t due;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("unexpected result, status", 0, out_data.status);
      end else begin
        due = verdict_q.pop_front();
        if (out_data.status !== due.status) note_mismatch("status", due.status, out_data.status);
        if (out_data.safe !== due.safe) note_mismatch("safe", due.safe, out_data.safe);
      end
    end
  end

  // watchdog: cycles with neither a command nor a result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [3:0] procs;
    logic [2:0] res;
  } setting_t;

  // register settings of the random phases, extremes and out-of-range values included
  setting_t phase_set [N_PHASES] = '{
    '{4'd8, 3'd4}, '{4'd1, 3'd1}, '{4'd15, 3'd7}, '{4'd3, 3'd2},
    '{4'd0, 3'd0}, '{4'd6, 3'd3}, '{4'd2, 3'd4}, '{4'd8, 3'd4}
  };

  initial begin : stimulus
    plan_row_t plan [];
    int        gap;
    // known values on every input from time zero
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = bkr_pkg::REG_ACTIVE_PROCESSES;
    cfg_wdata   = '0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    // predictor reset state
    proc_reg = 4'd8;
    res_reg  = 3'd4;
    foreach (held_tab[p, r]) begin
      held_tab[p][r] = '0;
      need_tab[p][r] = '0;
    end
    foreach (free_units[r]) free_units[r] = '0;

    plan = '{
      // empty tables after reset are trivially safe
      row_chk(bkr_pkg::FUNC_QUERY,      0, 0,   0,   0,   0,   bkr_pkg::STATUS_OK,  1'b1),
      row_chk(bkr_pkg::FUNC_LOAD_AVAIL, 0, 255, 255, 255, 255, bkr_pkg::STATUS_OK,  1'b1),
      row_chk(bkr_pkg::FUNC_LOAD_NEED,  7, 255, 255, 255, 255, bkr_pkg::STATUS_OK,  1'b1),
      // full grant of the whole pool to the last row
      row_chk(bkr_pkg::FUNC_REQUEST,    7, 255, 255, 255, 255, bkr_pkg::STATUS_OK,  1'b1),
      row_chk(bkr_pkg::FUNC_REQUEST,    7, 1,   0,   0,   0,
              bkr_pkg::STATUS_EXC_NEED, 1'b1),
      row_chk(bkr_pkg::FUNC_RELEASE,    7, 255, 255, 255, 255, bkr_pkg::STATUS_OK,  1'b1),
      row_chk(bkr_pkg::FUNC_RELEASE,    7, 1,   0,   0,   0,
              bkr_pkg::STATUS_EXC_HELD, 1'b1),
      row_chk(bkr_pkg::FUNC_LOAD_HELD,  0, 200, 0,   0,   0,   bkr_pkg::STATUS_OK,  1'b1),
      // release that would push free units past the unit maximum
      row_chk(bkr_pkg::FUNC_RELEASE,    0, 100, 0,   0,   0,
              bkr_pkg::STATUS_OVERFLOW, 1'b1),
      row_chk(bkr_pkg::FUNC_LOAD_AVAIL, 0, 0,   0,   0,   0,   bkr_pkg::STATUS_OK,  1'b0),
      // zero request on an already unsafe state is refused as unsafe
      row_chk(bkr_pkg::FUNC_REQUEST,    1, 0,   0,   0,   0,
              bkr_pkg::STATUS_UNSAFE, 1'b0),
      row_chk(bkr_pkg::FUNC_LOAD_NEED,  7, 0,   0,   0,   0,   bkr_pkg::STATUS_OK,  1'b1),
      row_chk(bkr_pkg::FUNC_LOAD_NEED,  2, 50,  50,  50,  50,  bkr_pkg::STATUS_OK,  1'b0),
      row_chk(bkr_pkg::FUNC_REQUEST,    2, 10,  0,   0,   0,
              bkr_pkg::STATUS_EXC_AVAIL, 1'b0),
      // held plus request above the unit maximum
      row(bkr_pkg::FUNC_LOAD_AVAIL, 0, 100, 0,   0,   0),
      row(bkr_pkg::FUNC_LOAD_NEED,  0, 100, 0,   0,   0),
      row(bkr_pkg::FUNC_REQUEST,    0, 60,  0,   0,   0),
      // spare codes change nothing
      row(FUNC_SPARE_6,             3, 170, 170, 170, 170),
      row(FUNC_SPARE_7,             4, 85,  85,  85,  85),
      // rows outside the active range are left alone
      row_cfg(bkr_pkg::REG_ACTIVE_PROCESSES, 2),
      row(bkr_pkg::FUNC_REQUEST,    5, 1,   1,   1,   1),
      row(bkr_pkg::FUNC_RELEASE,    5, 1,   1,   1,   1),
      // only the first column counts
      row_cfg(bkr_pkg::REG_ACTIVE_RESOURCES, 1),
      row(bkr_pkg::FUNC_REQUEST,    0, 10,  255, 255, 255),
      // zero registers clamp to one row and one column
      row_cfg(bkr_pkg::REG_ACTIVE_PROCESSES, 0),
      row_cfg(bkr_pkg::REG_ACTIVE_RESOURCES, 0),
      row(bkr_pkg::FUNC_QUERY,      0, 0,   0,   0,   0),
      // values above the maximum clamp to the full size
      row_cfg(bkr_pkg::REG_ACTIVE_PROCESSES, 15),
      row_cfg(bkr_pkg::REG_ACTIVE_RESOURCES, 7),
      row(bkr_pkg::FUNC_QUERY,      0, 0,   0,   0,   0),
      row_cfg(bkr_pkg::REG_ACTIVE_PROCESSES, 8),
      row_cfg(bkr_pkg::REG_ACTIVE_RESOURCES, 4),
      row(bkr_pkg::FUNC_RELEASE,    2, 0,   0,   0,   0)
    };

    // synchronous reset held low from time zero, released on a falling edge, never again
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        gap = next_gap();
        // start must be low before a register write or the random part
        if ((i == plan.size() - 1 || plan[i + 1].is_cfg) && gap == 0) gap = 1;
        issue(plan[i].item, plan[i].typed, plan[i].want, gap);
      end
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(bkr_pkg::REG_ACTIVE_PROCESSES, phase_set[ph].procs);
      write_reg(bkr_pkg::REG_ACTIVE_RESOURCES, {1'b0, phase_set[ph].res});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        gap = next_gap();
        if (n == ITEMS_PER_PHASE - 1 && gap == 0) gap = 1;
        issue(pick_operation(), 1'b0, '0, gap);
      end
    end

    // drain: every verdict must arrive, then a quiet tail for stray strobes
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
